>>> hw/rtl/stli_pkg.sv
// ----------------------------------------------------------------------------
// stli_pkg: shared types and constants
// Table depth, field widths, status codes and sequencer states.
// ----------------------------------------------------------------------------
package stli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] angle_in;
        logic signed [15:0] coeff_in;
    } t_req;

    typedef struct packed {
        logic signed [15:0] coeff_out;
        logic [1:0]         status;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LSCAN,
        S_LSHIFT,
        S_LPUT,
        S_QFIRST,
        S_QLAST,
        S_QSCAN,
        S_QPREV,
        S_QDIV,
        S_QSUM,
        S_OUT
    } t_state;

    // Divider handshake between the sequencer and the serial divider.
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

>>> hw/rtl/stli_if.sv
// ----------------------------------------------------------------------------
// stli_req_if / stli_rsp_if: valid-ready channels
// Carry one request or one response transaction per handshake.
// ----------------------------------------------------------------------------
interface stli_req_if;
    logic          valid;
    logic          ready;
    stli_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface stli_rsp_if;
    logic          valid;
    logic          ready;
    stli_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/stli_div.sv
// ----------------------------------------------------------------------------
// stli_div: serial signed divider
// Restoring division, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module stli_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stli_pkg::t_div_ctl    i_ctl,
    input  logic signed [33:0]    i_num,
    input  logic signed [17:0]    i_den,
    output stli_pkg::t_div_sts    o_sts,
    output logic signed [34:0]    o_quo
);
    logic [33:0] r_q;
    logic [33:0] n_q;
    logic [17:0] r_rem;
    logic [17:0] n_rem;
    logic [16:0] r_d;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [18:0] w_trial;
    logic [18:0] w_sub;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign w_trial = {r_rem, r_q[33]};
    assign w_sub   = w_trial - {2'b00, r_d};

    always_comb begin
        if (!w_sub[18]) begin
            n_rem = w_sub[17:0];
            n_q   = {r_q[32:0], 1'b1};
        end else begin
            n_rem = w_trial[17:0];
            n_q   = {r_q[32:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd34;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q   <= i_num[33] ? 34'(-i_num) : 34'(i_num);
            r_d   <= i_den[17] ? 17'(-i_den) : 17'(i_den);
            r_neg <= i_num[33] ^ i_den[17];
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_quo = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign o_sts = '{busy: r_busy, done: r_done};
endmodule

>>> hw/rtl/sorted_table_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_unit: sorted breakpoint table
// Inserts breakpoints in angle order and interpolates queries between them.
// ----------------------------------------------------------------------------
// Use: requests arrive on i_req (req_type, angle_in, coeff_in), one response
// per request leaves on o_rsp (coeff_out, status). A load inserts a point in
// angle order, after any equal angles; a full table answers status 2. A query
// answers 3 on an empty table, 1 outside the stored range, the stored value on
// an exact match, and otherwise a linear interpolation saturated to 16 bits.
// The table lives in two single-port memories with a registered read.
// A load scans the table for its position, then shifts the entries above it
// up one at a time through the memory port and writes the new point. A full
// table or an empty query goes straight to the response, without touching the
// memory; a range miss answers once the first or the last point is compared.
// A query scans up from position 0 to its bracket and answers there on an
// exact match; to interpolate it then reads the lower point, runs the serial
// divider and adds the quotient to the lower value. One request is in flight
// at a time; the block takes the next request only after the response leaves.
// Reset clears the state, the phase bit and the point count; the memories need no clearing. The
// response is held in an output register until taken; a stalled receiver
// holds the block, and no new request is taken until the response leaves.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stli_req_if.sink    i_req,
    stli_rsp_if.source  o_rsp
);
    localparam int IW = stli_pkg::IDX_W;
    localparam int CW = stli_pkg::CNT_W;

    logic signed [15:0] r_amem [stli_pkg::TABLE_DEPTH];
    logic signed [15:0] r_cmem [stli_pkg::TABLE_DEPTH];
    logic signed [15:0] r_ard;
    logic signed [15:0] r_crd;

    stli_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_ptr;
    logic [CW-1:0]    n_ptr;
    logic             r_phase;
    logic signed [15:0] r_a;
    logic signed [15:0] r_c;
    logic signed [15:0] r_sa, r_sc;
    logic signed [15:0] r_clo;
    logic signed [33:0] r_num;
    logic signed [17:0] r_den;
    logic signed [15:0] r_res_c;
    logic [1:0]         r_res_s;

    logic          w_re, w_we;
    logic [IW-1:0] w_raddr, w_waddr;
    logic signed [15:0] w_wa, w_wc;
    logic          w_fire;
    stli_pkg::t_div_ctl w_dctl;
    stli_pkg::t_div_sts w_dsts;
    logic signed [34:0] w_quo;
    logic signed [35:0] w_sum;

    assign w_fire = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == stli_pkg::S_IDLE);
    assign o_rsp.valid = (r_state == stli_pkg::S_OUT);
    assign o_rsp.payload = '{coeff_out: r_res_c, status: r_res_s};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_amem[w_waddr] <= w_wa;
            r_cmem[w_waddr] <= w_wc;
        end
        if (w_re) begin
            r_ard <= r_amem[w_raddr];
            r_crd <= r_cmem[w_raddr];
        end
    end

    stli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dctl),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_sts   (w_dsts),
        .o_quo   (w_quo)
    );

    assign w_sum = 36'(r_clo) + 36'(w_quo);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            stli_pkg::S_IDLE: begin
                if (w_fire) begin
                    if (!i_req.payload.req_type) begin
                        n_state = (r_count == CW'(stli_pkg::TABLE_DEPTH)) ?
                                  stli_pkg::S_OUT : stli_pkg::S_LSCAN;
                    end else begin
                        n_state = (r_count == '0) ? stli_pkg::S_OUT :
                                  stli_pkg::S_QFIRST;
                    end
                end
            end
            stli_pkg::S_LSCAN: begin
                if (r_ptr == r_count) begin
                    n_state = stli_pkg::S_LSHIFT;
                end else if (r_phase && r_ard > r_a) begin
                    n_state = stli_pkg::S_LSHIFT;
                end
            end
            stli_pkg::S_LSHIFT: begin
                if (r_ptr == r_sa[CW-1:0]) n_state = stli_pkg::S_LPUT;
            end
            stli_pkg::S_LPUT:   n_state = stli_pkg::S_OUT;
            stli_pkg::S_QFIRST: begin
                if (r_phase) begin
                    n_state = (r_a < r_ard) ? stli_pkg::S_OUT : stli_pkg::S_QLAST;
                end
            end
            stli_pkg::S_QLAST: begin
                if (r_phase) begin
                    n_state = (r_a > r_ard) ? stli_pkg::S_OUT : stli_pkg::S_QSCAN;
                end
            end
            stli_pkg::S_QSCAN: begin
                if (r_phase && (r_ard >= r_a)) begin
                    n_state = (r_ard == r_a) ? stli_pkg::S_OUT : stli_pkg::S_QPREV;
                end
            end
            stli_pkg::S_QPREV: if (r_phase) n_state = stli_pkg::S_QDIV;
            stli_pkg::S_QDIV:  if (w_dsts.done) n_state = stli_pkg::S_QSUM;
            stli_pkg::S_QSUM:  n_state = stli_pkg::S_OUT;
            stli_pkg::S_OUT:   if (o_rsp.ready) n_state = stli_pkg::S_IDLE;
            default:           n_state = stli_pkg::S_IDLE;
        endcase
    end

    // Memory port and divider controls.
    always_comb begin
        w_re    = 1'b0;
        w_we    = 1'b0;
        w_raddr = r_ptr[IW-1:0];
        w_waddr = r_ptr[IW-1:0];
        w_wa    = r_ard;
        w_wc    = r_crd;
        w_dctl  = '{start: 1'b0};
        n_ptr   = r_ptr;
        case (r_state)
            stli_pkg::S_IDLE: begin
                n_ptr = '0;
            end
            stli_pkg::S_LSCAN: begin
                // On leaving the scan the pointer moves to the end of the table.
                if (r_ptr != r_count) begin
                    if (!r_phase) begin
                        w_re = 1'b1;
                    end else if (r_ard > r_a) begin
                        n_ptr = r_count;
                    end else begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end
            end
            stli_pkg::S_LSHIFT: begin
                // r_sa low bits hold the insert position; r_ptr walks down.
                if (r_ptr != r_sa[CW-1:0]) begin
                    if (!r_phase) begin
                        w_re    = 1'b1;
                        w_raddr = IW'(r_ptr - CW'(1));
                    end else begin
                        w_we  = 1'b1;
                        n_ptr = r_ptr - CW'(1);
                    end
                end
            end
            stli_pkg::S_LPUT: begin
                w_we    = 1'b1;
                w_waddr = r_ptr[IW-1:0];
                w_wa    = r_a;
                w_wc    = r_c;
            end
            stli_pkg::S_QFIRST: begin
                w_re    = !r_phase;
                w_raddr = '0;
            end
            stli_pkg::S_QLAST: begin
                w_re    = !r_phase;
                w_raddr = IW'(r_count - CW'(1));
            end
            stli_pkg::S_QSCAN: begin
                w_re = !r_phase;
                if (r_phase && !(r_ard >= r_a)) n_ptr = r_ptr + CW'(1);
            end
            stli_pkg::S_QPREV: begin
                w_re    = !r_phase;
                w_raddr = IW'(r_ptr - CW'(1));
            end
            stli_pkg::S_QDIV: begin
                // The operands are registered by now; start once on entry.
                w_dctl = '{start: !w_dsts.busy && !w_dsts.done};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stli_pkg::S_IDLE;
            r_count <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= (n_state == r_state) ? !r_phase : 1'b0;
            if (r_state == stli_pkg::S_LPUT) r_count <= r_count + CW'(1);
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        case (r_state)
            stli_pkg::S_IDLE: begin
                r_a     <= i_req.payload.angle_in;
                r_c     <= i_req.payload.coeff_in;
                r_res_c <= '0;
                r_res_s <= i_req.payload.req_type ? stli_pkg::ST_EMPTY :
                           stli_pkg::ST_FULL;
            end
            stli_pkg::S_LSCAN: begin
                if (n_state == stli_pkg::S_LSHIFT) begin
                    r_sa <= 16'(r_ptr);
                end
            end
            stli_pkg::S_LSHIFT: begin
                if (n_state == stli_pkg::S_LPUT) begin
                    r_res_s <= stli_pkg::ST_OK;
                end
            end
            stli_pkg::S_QFIRST: begin
                if (r_phase && r_a < r_ard) begin
                    r_res_s <= stli_pkg::ST_RANGE;
                end
            end
            stli_pkg::S_QLAST: begin
                if (r_phase && r_a > r_ard) begin
                    r_res_s <= stli_pkg::ST_RANGE;
                end
            end
            stli_pkg::S_QSCAN: begin
                if (r_phase && r_ard == r_a) begin
                    r_res_c <= r_crd;
                    r_res_s <= stli_pkg::ST_OK;
                end
                r_sa <= r_ard;
                r_sc <= r_crd;
            end
            stli_pkg::S_QPREV: begin
                if (r_phase) begin
                    r_clo <= r_crd;
                    r_num <= 34'(17'(r_a) - 17'(r_ard)) * 34'(17'(r_sc) - 17'(r_crd));
                    r_den <= 18'(r_sa) - 18'(r_ard);
                end
            end
            stli_pkg::S_QSUM: begin
                r_res_s <= stli_pkg::ST_OK;
                if (w_sum > 36'sd32767)       r_res_c <= 16'sh7FFF;
                else if (w_sum < -36'sd32768) r_res_c <= 16'sh8000;
                else                          r_res_c <= w_sum[15:0];
            end
            default: ;
        endcase
    end

    // Assertions.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(stli_pkg::TABLE_DEPTH))
        else $error("point count beyond table depth");
    a_rsp_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready) |=> !o_rsp.valid)
        else $error("response repeated");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != stli_pkg::S_IDLE) |-> !i_req.ready)
        else $error("request taken while busy");
    a_load_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stli_pkg::S_LPUT) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow table");
endmodule

>>> test/tb_sorted_table_linear_interpolator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_table_linear_interpolator_unit: self-checking bench
// Loads breakpoints and sends queries, predicts each response with a local
// model of the sorted table, and compares every response as it arrives.
// ----------------------------------------------------------------------------
module tb_sorted_table_linear_interpolator_unit;

    logic i_clk;
    logic i_rst_n;
    stli_req_if req_ch ();
    stli_rsp_if rsp_ch ();

    sorted_table_linear_interpolator_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    localparam int CYCLE_LIMIT = 400000;

    // Local copy of the breakpoint table.
    logic signed [15:0] tbl_angle [stli_pkg::TABLE_DEPTH];
    logic signed [15:0] tbl_coeff [stli_pkg::TABLE_DEPTH];
    int                 tbl_count;

    stli_pkg::t_rsp pending_rsp [$];
    int   error_count;
    int   cycle_count = 0;
    bit   idle_enable;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sorted_table_linear_interpolator_unit: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic stli_pkg::t_rsp predict_response(input stli_pkg::t_req req);
        stli_pkg::t_rsp rsp;
        int           pos;
        int           hi;
        longint       num;
        longint       den;
        longint       sum;
        rsp.coeff_out = '0;
        rsp.status    = stli_pkg::ST_OK;
        hi            = -1;
        if (req.req_type == 1'b0) begin
            if (tbl_count >= stli_pkg::TABLE_DEPTH) begin
                rsp.status = stli_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < tbl_count && tbl_angle[pos] <= req.angle_in) pos++;
                for (int k = tbl_count; k > pos; k--) begin
                    tbl_angle[k] = tbl_angle[k-1];
                    tbl_coeff[k] = tbl_coeff[k-1];
                end
                tbl_angle[pos] = req.angle_in;
                tbl_coeff[pos] = req.coeff_in;
                tbl_count++;
            end
        end else if (tbl_count == 0) begin
            rsp.status = stli_pkg::ST_EMPTY;
        end else if (req.angle_in < tbl_angle[0] ||
                     req.angle_in > tbl_angle[tbl_count-1]) begin
            rsp.status = stli_pkg::ST_RANGE;
        end else begin
            for (int i = 0; i < tbl_count; i++) begin
                if (tbl_angle[i] == req.angle_in) begin
                    rsp.coeff_out = tbl_coeff[i];
                    return rsp;
                end
                if (tbl_angle[i] > req.angle_in) begin
                    hi = i;
                    break;
                end
            end
            num = (longint'(req.angle_in) - longint'(tbl_angle[hi-1])) *
                  (longint'(tbl_coeff[hi]) - longint'(tbl_coeff[hi-1]));
            den = longint'(tbl_angle[hi]) - longint'(tbl_angle[hi-1]);
            sum = longint'(tbl_coeff[hi-1]) + num / den;
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            rsp.coeff_out = sum[15:0];
        end
        return rsp;
    endfunction

    // Valid stays high from one transaction to the next unless a gap is drawn.
    task automatic send_request(input logic kind, input logic [15:0] ang,
                                input logic [15:0] cf);
        stli_pkg::t_req req;
        int   gap;
        req.req_type = kind;
        req.angle_in = ang;
        req.coeff_in = cf;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= req;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_rsp.insert(pending_rsp.size(), predict_response(req));
    endtask

    // Receiver: random stall bursts, then compare each response transaction.
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (idle_enable && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                stall = $urandom_range(1, 19);
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("response with nothing expected");
                end else begin
                    stli_pkg::t_rsp exp_rsp;
                    exp_rsp = pending_rsp.pop_front();
                    if (rsp_ch.payload.coeff_out !== exp_rsp.coeff_out)
                        report_mismatch($sformatf("coeff_out %0d, expected %0d",
                            $signed(rsp_ch.payload.coeff_out),
                            $signed(exp_rsp.coeff_out)));
                    if (rsp_ch.payload.status !== exp_rsp.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                            rsp_ch.payload.status, exp_rsp.status));
                end
            end
        end
    end

    task automatic test_empty_and_edges();
        send_request(1'b1, 16'h0000, 16'h0);                 // empty table
        send_request(1'b0, 16'h8000, 16'h8000);
        send_request(1'b1, 16'h8000, 16'hFFFF);              // single point match
        send_request(1'b1, 16'h8001, 16'h0);                 // above only point
        send_request(1'b0, 16'h7FFF, 16'h7FFF);
        send_request(1'b1, 16'h0000, 16'h0);                 // wide bracket
        send_request(1'b1, 16'h7FFE, 16'h0);
        send_request(1'b1, 16'h7FFF, 16'h0);                 // last angle
        send_request(1'b0, 16'h0000, 16'h8000);
        send_request(1'b0, 16'h0000, 16'h1234);              // duplicate angle
        send_request(1'b1, 16'h0000, 16'h0);                 // earliest duplicate
        send_request(1'b1, 16'h0001, 16'h0);
        send_request(1'b1, 16'hFFFF, 16'h0);
        send_request(1'b0, 16'h0100, 16'h7FFF);
        send_request(1'b0, 16'h0200, 16'h8000);
        send_request(1'b1, 16'h0180, 16'h0);
        send_request(1'b1, 16'h00C0, 16'h0);
    endtask

    // Fill beyond capacity so the full-table status is seen, then query.
    task automatic test_full_table();
        while (tbl_count < stli_pkg::TABLE_DEPTH)
            send_request(1'b0, 16'($urandom), 16'($urandom));
        send_request(1'b0, 16'h1111, 16'h2222);
        send_request(1'b0, 16'h8000, 16'h7FFF);
        for (int n = 0; n < 150; n++)
            send_request($urandom_range(0, 7) == 0 ? 1'b0 : 1'b1,
                         16'($urandom), 16'($urandom));
    endtask

    // A fresh table would need reset, which is asserted only once, so the
    // random part reuses the full table with queries at or near stored angles and at random angles.
    task automatic test_random_queries();
        logic [15:0] ang;
        for (int n = 0; n < 330; n++) begin
            if (n == 250) idle_enable = 1'b0;
            case ($urandom_range(0, 3))
                0: ang = tbl_angle[$urandom_range(0, stli_pkg::TABLE_DEPTH - 1)];
                1: ang = tbl_angle[$urandom_range(0, stli_pkg::TABLE_DEPTH - 1)] +
                         16'($urandom_range(0, 6)) - 16'd3;
                default: ang = 16'($urandom);
            endcase
            send_request($urandom_range(0, 15) == 0 ? 1'b0 : 1'b1,
                         ang, 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        tbl_count      = 0;
        error_count    = 0;
        idle_enable    = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_edges();
        test_full_table();
        test_random_queries();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_sorted_table_linear_interpolator_unit: done, clean");
        end else begin
            $display("tb_sorted_table_linear_interpolator_unit: done, errors");
        end
        $finish;
    end

endmodule

>>> sorted_table_linear_interpolator_unit.f
hw/rtl/stli_pkg.sv
hw/rtl/stli_if.sv
hw/rtl/stli_div.sv
hw/rtl/sorted_table_linear_interpolator_unit.sv
test/tb_sorted_table_linear_interpolator_unit.sv
